/* rtl/core/bda_pkg.sv */
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the batched direction arbiter.
// ----------------------------------------------------------------------------
package bda_pkg;

    typedef logic [1:0] t_dir;
    typedef logic [7:0] t_count;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_EXIT   = 1'b1;

    localparam t_count BATCH_LIMIT_RST = 8'd10;

    typedef struct packed {
        logic kind;
        t_dir origin;
    } t_event;

    typedef struct packed {
        logic   admitted;
        logic   light_changed;
        t_dir   green_direction;
        t_count released_count;
        logic   stop_active;
    } t_result;

endpackage

/* rtl/core/batched_direction_arbiter_unit.sv */
// ----------------------------------------------------------------------------
// batched_direction_arbiter_unit
// Four-way batched access arbiter with saturating car counts.
// ----------------------------------------------------------------------------
// One event transaction in, one result transaction out. An event is registered,
// then the state update and the rotate search over the four waiting counts run
// combinationally into the result register; a new event is taken every cycle
// and throughput is limited only by output backpressure.
// batch_limit is written through the cfg channel, which is always ready; write
// it only while no event is in flight. Counts saturate at min(MAX_CARS, 255).
module batched_direction_arbiter_unit #(
    parameter int MAX_CARS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [1:0] i_origin,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_admitted,
    output logic       o_light_changed,
    output logic [1:0] o_green_direction,
    output logic [7:0] o_released_count,
    output logic       o_stop_active,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_batch_limit
);

    bda_pkg::t_event  in_event;
    bda_pkg::t_event  core_event;
    bda_pkg::t_result core_result;
    bda_pkg::t_result out_result;
    logic             core_valid;
    logic             out_space;
    logic             fire;

    assign in_event.kind   = i_kind;
    assign in_event.origin = i_origin;
    assign fire            = core_valid && out_space;
    assign o_cfg_ready     = 1'b1;

    bda_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_event (in_event),
        .i_take  (fire),
        .o_valid (core_valid),
        .o_event (core_event)
    );

    bda_state #(
        .MAX_CARS (MAX_CARS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_batch_limit),
        .i_fire     (fire),
        .i_event    (core_event),
        .o_result   (core_result)
    );

    bda_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .i_ready  (i_ready),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_admitted        = out_result.admitted;
    assign o_light_changed   = out_result.light_changed;
    assign o_green_direction = out_result.green_direction;
    assign o_released_count  = out_result.released_count;
    assign o_stop_active     = out_result.stop_active;

endmodule

/* rtl/core/bda_in_reg.sv */
// ----------------------------------------------------------------------------
// bda_in_reg
// Input register: holds one event transaction until the core consumes it.
// ----------------------------------------------------------------------------
module bda_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bda_pkg::t_event i_event,
    input  logic            i_take,
    output logic            o_valid,
    output bda_pkg::t_event o_event
);

    logic            r_valid;
    bda_pkg::t_event r_event;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_event <= i_event;
        end
    end

endmodule

/* rtl/core/bda_state.sv */
// ----------------------------------------------------------------------------
// bda_state
// Arbiter state, batch limit register and combinational event update.
// ----------------------------------------------------------------------------
module bda_state #(
    parameter int MAX_CARS = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  bda_pkg::t_count  i_cfg_data,
    input  logic             i_fire,
    input  bda_pkg::t_event  i_event,
    output bda_pkg::t_result o_result
);

    localparam bda_pkg::t_count CAP = (MAX_CARS < 255) ? 8'(MAX_CARS) : 8'd255;

    function automatic bda_pkg::t_count sat_add(input bda_pkg::t_count a,
                                                input bda_pkg::t_count b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, CAP}) ? CAP : sum[7:0];
    endfunction

    bda_pkg::t_count r_limit;
    bda_pkg::t_dir   r_green;
    logic            r_stop;
    bda_pkg::t_count r_entered;
    bda_pkg::t_count r_exited;
    bda_pkg::t_count r_wait [4];

    bda_pkg::t_dir   n_green;
    logic            n_stop;
    bda_pkg::t_count n_entered;
    bda_pkg::t_count n_exited;
    bda_pkg::t_count n_wait [4];

    logic [3:0]      nz;
    bda_pkg::t_dir   g1, g2, g3, sg;
    bda_pkg::t_count ex_inc;

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            nz[d] = (r_wait[d] != 8'd0);
        end
        g1 = r_green + 2'd1;
        g2 = r_green + 2'd2;
        g3 = r_green + 2'd3;
        if (nz[g1]) begin
            sg = g1;
        end else if (nz[g2]) begin
            sg = g2;
        end else if (nz[g3]) begin
            sg = g3;
        end else begin
            sg = r_green;
        end
        ex_inc = sat_add(r_exited, 8'd1);
    end

    always_comb begin
        n_green   = r_green;
        n_stop    = r_stop;
        n_entered = r_entered;
        n_exited  = r_exited;
        for (int d = 0; d < 4; d++) begin
            n_wait[d] = r_wait[d];
        end
        o_result = '0;

        if (i_event.kind == bda_pkg::KIND_ARRIVE) begin
            if (i_event.origin == r_green && !r_stop) begin
                o_result.admitted = 1'b1;
                if (r_entered >= r_limit) begin
                    n_stop = 1'b1;
                end
                n_entered = sat_add(r_entered, 8'd1);
            end else if (!r_stop && r_entered == r_exited) begin
                o_result.admitted       = 1'b1;
                o_result.light_changed  = 1'b1;
                n_green                 = i_event.origin;
                o_result.released_count = r_wait[i_event.origin];
                n_wait[i_event.origin]  = 8'd0;
                n_entered               = sat_add(8'd1, r_wait[i_event.origin]);
                n_exited                = 8'd0;
            end else begin
                n_wait[i_event.origin] = sat_add(r_wait[i_event.origin], 8'd1);
            end
        end else begin
            n_exited = ex_inc;
            if (ex_inc == r_entered) begin
                n_stop                  = 1'b0;
                o_result.light_changed  = 1'b1;
                n_green                 = sg;
                o_result.released_count = r_wait[sg];
                n_wait[sg]              = 8'd0;
                n_entered               = r_wait[sg];
                n_exited                = 8'd0;
            end
        end

        o_result.green_direction = n_green;
        o_result.stop_active     = n_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= bda_pkg::BATCH_LIMIT_RST;
            r_green   <= 2'd0;
            r_stop    <= 1'b0;
            r_entered <= 8'd0;
            r_exited  <= 8'd0;
            for (int d = 0; d < 4; d++) begin
                r_wait[d] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_fire) begin
                r_green   <= n_green;
                r_stop    <= n_stop;
                r_entered <= n_entered;
                r_exited  <= n_exited;
                for (int d = 0; d < 4; d++) begin
                    r_wait[d] <= n_wait[d];
                end
            end
        end
    end

endmodule

/* rtl/core/bda_out_reg.sv */
// ----------------------------------------------------------------------------
// bda_out_reg
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module bda_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bda_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output bda_pkg::t_result o_result
);

    logic             r_valid;
    bda_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/bda_checker.sv */
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for the batched direction arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module bda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_admitted,
    input logic       o_light_changed,
    input logic [1:0] o_green_direction,
    input logic [7:0] o_released_count,
    input logic       o_stop_active
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_admitted)
            && $stable(o_light_changed) && $stable(o_green_direction)
            && $stable(o_released_count) && $stable(o_stop_active))
        else $error("result transaction changed while stalled");

    a_release_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_light_changed |-> o_released_count == 8'd0)
        else $error("waiters released without a light change");

    a_change_clears_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_light_changed |-> !o_stop_active)
        else $error("stop flag set after a light change");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind batched_direction_arbiter_unit bda_checker u_bda_checker (.*);

/* bench/batched_direction_arbiter_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_direction_arbiter_unit_test
// Self-checking bench for the four-way batched direction arbiter. A directed
// walk through queueing, jumps and rotations is followed by a counter
// saturation run and random traffic at several batch limits. Both sides
// idle and stall at random, with one long output stall. Every result is
// checked field by field against a cycle-free predictor.
// ----------------------------------------------------------------------------
module batched_direction_arbiter_unit_test;

    localparam int CAR_CAP     = 255;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 300;
    localparam int MAX_REPORTS = 40;
    localparam int PHASE_ITEMS = 125;

    localparam bda_pkg::t_dir DIR_NORTH = 2'd0;
    localparam bda_pkg::t_dir DIR_EAST  = 2'd1;
    localparam bda_pkg::t_dir DIR_SOUTH = 2'd2;
    localparam bda_pkg::t_dir DIR_WEST  = 2'd3;

    class ArbiterScoreboard;
        bda_pkg::t_dir    lamp_dir;
        bit               stopped;
        int               cars_in;
        int               cars_out;
        int               queued[4];
        bda_pkg::t_count  limit;
        bda_pkg::t_result outcome_q[$];
        int               errors;
        int               reports;

        function new();
            lamp_dir = DIR_NORTH;
            stopped  = 1'b0;
            cars_in  = 0;
            cars_out = 0;
            foreach (queued[i]) queued[i] = 0;
            limit    = bda_pkg::BATCH_LIMIT_RST;
            errors   = 0;
            reports  = 0;
        endfunction

        function int bump(int a, int b);
            return (a + b > CAR_CAP) ? CAR_CAP : a + b;
        endfunction

        function void set_limit(bda_pkg::t_count v);
            limit = v;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Accepted event transaction: advance the arbiter state, queue the outcome.
        function void note_event(logic kind, bda_pkg::t_dir origin);
            bda_pkg::t_result r;
            int               steps;
            r = '0;
            if (kind == bda_pkg::KIND_ARRIVE) begin
                if (origin == lamp_dir && !stopped) begin
                    r.admitted = 1'b1;
                    if (cars_in >= int'(limit)) stopped = 1'b1;
                    cars_in = bump(cars_in, 1);
                end else if (!stopped && cars_in == cars_out) begin
                    r.admitted       = 1'b1;
                    r.light_changed  = 1'b1;
                    lamp_dir         = origin;
                    r.released_count = bda_pkg::t_count'(queued[origin]);
                    queued[origin]   = 0;
                    cars_in          = bump(1, int'(r.released_count));
                    cars_out         = 0;
                end else begin
                    queued[origin] = bump(queued[origin], 1);
                end
            end else begin
                cars_out = bump(cars_out, 1);
                if (cars_out == cars_in) begin
                    stopped         = 1'b0;
                    r.light_changed = 1'b1;
                    steps           = 0;
                    do begin
                        steps++;
                        lamp_dir = lamp_dir + 2'd1;
                    end while (queued[lamp_dir] == 0 && steps < 4);
                    r.released_count = bda_pkg::t_count'(queued[lamp_dir]);
                    queued[lamp_dir] = 0;
                    cars_in          = int'(r.released_count);
                    cars_out         = 0;
                end
            end
            r.green_direction = lamp_dir;
            r.stop_active     = stopped;
            outcome_q.push_back(r);
        endfunction

        function void match_field(string what, int want, int got);
            if (want != got) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: %s mismatch, expected %0d actual %0d",
                             $time, what, want, got);
                end
            end
        endfunction

        function void check_result(bda_pkg::t_result got);
            bda_pkg::t_result want;
            if (outcome_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result transaction with no event pending", $time);
                end
                return;
            end
            want = outcome_q.pop_front();
            match_field("admitted", want.admitted, got.admitted);
            match_field("light_changed", want.light_changed, got.light_changed);
            match_field("green_direction", want.green_direction, got.green_direction);
            match_field("released_count", want.released_count, got.released_count);
            match_field("stop_active", want.stop_active, got.stop_active);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_kind;
    logic [1:0] i_origin;
    logic       o_valid;
    logic       i_ready;
    logic       o_admitted;
    logic       o_light_changed;
    logic [1:0] o_green_direction;
    logic [7:0] o_released_count;
    logic       o_stop_active;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_batch_limit;

    ArbiterScoreboard sb;
    bda_pkg::t_result seen;
    int               cycles = 0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    bit               calm = 1'b0;
    bit               hold_req = 1'b0;
    int               idle_levels[4] = '{0, 10, 30, 60};

    batched_direction_arbiter_unit #(
        .MAX_CARS(CAR_CAP)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_origin          (i_origin),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_admitted        (o_admitted),
        .o_light_changed   (o_light_changed),
        .o_green_direction (o_green_direction),
        .o_released_count  (o_released_count),
        .o_stop_active     (o_stop_active),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_batch_limit (i_cfg_batch_limit)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("batched_direction_arbiter_unit_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            seen.admitted        = o_admitted;
            seen.light_changed   = o_light_changed;
            seen.green_direction = o_green_direction;
            seen.released_count  = o_released_count;
            seen.stop_active     = o_stop_active;
            sb.check_result(seen);
        end
    end

    // Result side backpressure: random stall bursts, one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                stall_left = LONG_STALL;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_event(logic kind, bda_pkg::t_dir origin);
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_origin <= origin;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_event(kind, origin);
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(bda_pkg::t_count v);
        drain();
        i_cfg_valid       <= 1'b1;
        i_cfg_batch_limit <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_limit(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: exits only while cars are inside, arrivals
    // biased toward the green direction; a slice of unconstrained noise.
    function automatic void pick_event(int exit_pct, output logic kind,
                                       output bda_pkg::t_dir origin);
        origin = bda_pkg::t_dir'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 12) begin
            kind = 1'($urandom_range(0, 1));
        end else if (sb.cars_in > sb.cars_out && $urandom_range(0, 99) < exit_pct) begin
            kind = bda_pkg::KIND_EXIT;
        end else begin
            kind = bda_pkg::KIND_ARRIVE;
            if ($urandom_range(0, 1) == 1) origin = sb.lamp_dir;
        end
    endfunction

    // Drive waiting and car counts into saturation, then drain the batch.
    task automatic saturation_run();
        int            guard;
        bda_pkg::t_dir far_dir;
        write_limit(8'd255);
        guard = 0;
        while (sb.cars_in > sb.cars_out && guard < 600) begin
            send_event(bda_pkg::KIND_EXIT, bda_pkg::t_dir'($urandom_range(0, 3)));
            guard++;
        end
        send_event(bda_pkg::KIND_ARRIVE, sb.lamp_dir);
        far_dir = sb.lamp_dir + 2'd2;
        repeat (270) send_event(bda_pkg::KIND_ARRIVE, far_dir);
        guard = 0;
        while (sb.cars_in > sb.cars_out && guard < 600) begin
            if (guard % 50 == 7) send_event(bda_pkg::KIND_ARRIVE, sb.lamp_dir);
            else send_event(bda_pkg::KIND_EXIT, bda_pkg::t_dir'($urandom_range(0, 3)));
            guard++;
        end
    endtask

    initial begin
        int              p;
        int              exit_pct;
        logic            kind;
        bda_pkg::t_dir   origin;
        bda_pkg::t_count lim;

        sb = new();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_kind            <= bda_pkg::KIND_ARRIVE;
        i_origin          <= DIR_NORTH;
        i_cfg_valid       <= 1'b0;
        i_cfg_batch_limit <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // exit while empty, then catch-up admission and a jump
        send_event(bda_pkg::KIND_EXIT, DIR_WEST);
        send_event(bda_pkg::KIND_ARRIVE, DIR_NORTH);
        send_event(bda_pkg::KIND_ARRIVE, DIR_EAST);
        send_event(bda_pkg::KIND_ARRIVE, DIR_SOUTH);
        send_event(bda_pkg::KIND_ARRIVE, DIR_WEST);
        send_event(bda_pkg::KIND_ARRIVE, DIR_NORTH);
        send_event(bda_pkg::KIND_ARRIVE, DIR_EAST);
        // last exits rotate through each waiting direction
        send_event(bda_pkg::KIND_EXIT, DIR_NORTH);
        send_event(bda_pkg::KIND_EXIT, DIR_EAST);
        send_event(bda_pkg::KIND_EXIT, DIR_SOUTH);
        send_event(bda_pkg::KIND_EXIT, DIR_WEST);
        // no waiters: full turn back to the same direction
        send_event(bda_pkg::KIND_EXIT, DIR_NORTH);
        send_event(bda_pkg::KIND_ARRIVE, DIR_WEST);
        send_event(bda_pkg::KIND_ARRIVE, DIR_NORTH);
        send_event(bda_pkg::KIND_ARRIVE, DIR_NORTH);
        send_event(bda_pkg::KIND_EXIT, DIR_SOUTH);
        send_event(bda_pkg::KIND_EXIT, DIR_EAST);
        send_event(bda_pkg::KIND_EXIT, DIR_WEST);

        for (p = 0; p < 8; p++) begin
            case (p)
                1: lim = 8'd0;
                2: lim = 8'd1;
                3: lim = 8'd2;
                4: lim = bda_pkg::t_count'($urandom_range(1, 254));
                5: lim = 8'd3;
                6: lim = bda_pkg::t_count'($urandom_range(1, 254));
                7: lim = 8'd5;
                default: lim = bda_pkg::BATCH_LIMIT_RST;
            endcase
            if (p == 1) saturation_run();
            if (p != 0) write_limit(lim);
            calm        = (p >= 6);
            tx_idle_pct = calm ? 0 : idle_levels[2'($urandom_range(0, 3))];
            rx_idle_pct = calm ? 0 : idle_levels[2'($urandom_range(0, 3))];
            if (p == 2) begin
                tx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            exit_pct = $urandom_range(25, 60);
            repeat (PHASE_ITEMS) begin
                pick_event(exit_pct, kind, origin);
                send_event(kind, origin);
            end
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("batched_direction_arbiter_unit_test OK");
        end else begin
            $display("batched_direction_arbiter_unit_test NOT OK");
        end
        $finish;
    end

endmodule
